@@ src/rktf_pkg.sv @@
// Package for the tape record framer: queue entry type, sequencer step codes
// and framing constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rktf_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'hE6;
	localparam logic [7:0] PAD_BYTE  = 8'h00;

	// One classified body byte, as the front hands it to the back.
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        hdr;
		logic        last;
		logic [15:0] load_addr;
		logic [15:0] end_addr;
		logic [15:0] checksum;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [3:0] {
		STEP_IDLE,
		STEP_LOAD_HI,
		STEP_LOAD_LO,
		STEP_END_HI,
		STEP_END_LO,
		STEP_BODY,
		STEP_PAD0,
		STEP_PAD1,
		STEP_SYNC,
		STEP_CS_HI,
		STEP_CS_LO
	} step_t;

endpackage
`default_nettype wire

@@ src/rktf_in_if.sv @@
// Input channel of the tape record framer: valid/ready plus one body byte.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface rktf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_last;

	modport source (output valid, output data_byte, output is_last, input ready);
	modport sink (input valid, input data_byte, input is_last, output ready);
endinterface
`default_nettype wire

@@ src/rktf_out_if.sv @@
// Output channel of the tape record framer: valid/ready plus one record byte.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface rktf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;
	logic       record_end;

	modport source (output valid, output out_byte, output run_end, output record_end,
		input ready);
	modport sink (input valid, input out_byte, input run_end, input record_end,
		output ready);
endinterface
`default_nettype wire

@@ src/rktf_front.sv @@
// Front of the tape record framer: accepts body bytes, tracks the record and
// the running checksum, and pushes classified commands. Uses rktf_pkg, rktf_in_if.
`timescale 1ns / 1ps
`default_nettype none
module rktf_front (
	input  wire                  clk,
	input  wire                  arst_n,
	rktf_in_if.sink              in_ch,
	input  wire [15:0]           load_address,
	input  wire [16:0]           body_length,
	input  rktf_pkg::q_stat_t    q_stat,
	output logic                 push,
	output rktf_pkg::cmd_t       push_cmd
);
	import rktf_pkg::*;

	logic        in_record_q;
	logic [15:0] sum_q;
	logic [15:0] base_sum;
	logic [15:0] end_addr;

	assign in_ch.ready = !q_stat.full;
	assign push        = in_ch.valid && in_ch.ready;

	// A record restarts the checksum at zero on its first byte.
	assign base_sum = in_record_q ? sum_q : 16'h0000;
	assign end_addr = load_address + body_length[15:0] - 16'd1;

	always_comb begin
		push_cmd.data_byte = in_ch.data_byte;
		push_cmd.hdr       = !in_record_q;
		push_cmd.last      = in_ch.is_last;
		push_cmd.load_addr = load_address;
		push_cmd.end_addr  = end_addr;
		// The last byte only touches the low checksum byte.
		push_cmd.checksum  = {base_sum[15:8], base_sum[7:0] + in_ch.data_byte};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_record_q <= 1'b0;
			sum_q       <= 16'h0000;
		end else if (push) begin
			if (in_ch.is_last) begin
				in_record_q <= 1'b0;
				sum_q       <= 16'h0000;
			end else begin
				in_record_q <= 1'b1;
				sum_q       <= base_sum + {in_ch.data_byte, in_ch.data_byte};
			end
		end
	end
endmodule
`default_nettype wire

@@ src/rktf_queue.sv @@
// Short command queue between front and back of the tape record framer.
// Uses rktf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rktf_queue #(
	parameter int DEPTH = 4
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  rktf_pkg::cmd_t       push_cmd,
	input  wire                  pop,
	output rktf_pkg::cmd_t       head_cmd,
	output rktf_pkg::q_stat_t    q_stat
);
	import rktf_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_stat.full  = (count_q == CNT_W'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head_cmd     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end
endmodule
`default_nettype wire

@@ src/rktf_back.sv @@
// Back of the tape record framer: steps through header, body and footer bytes
// of each command into the output register. Uses rktf_pkg, rktf_out_if.
`timescale 1ns / 1ps
`default_nettype none
module rktf_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  rktf_pkg::cmd_t       head_cmd,
	input  rktf_pkg::q_stat_t    q_stat,
	output logic                 pop,
	rktf_out_if.source           out_ch
);
	import rktf_pkg::*;

	step_t      step_q;
	step_t      step_d;
	step_t      cur;
	logic       advance;
	logic       emit;
	logic       final_step;
	logic [7:0] byte_d;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       run_end_q;
	logic       record_end_q;

	assign advance           = !valid_q || out_ch.ready;
	assign emit              = advance && !q_stat.empty;
	assign out_ch.valid      = valid_q;
	assign out_ch.out_byte   = byte_q;
	assign out_ch.run_end    = run_end_q;
	assign out_ch.record_end = record_end_q;

	always_comb begin
		if (step_q == STEP_IDLE) begin
			cur = head_cmd.hdr ? STEP_LOAD_HI : STEP_BODY;
		end else begin
			cur = step_q;
		end
		final_step = (cur == STEP_CS_LO) || (cur == STEP_BODY && !head_cmd.last);
		pop        = emit && final_step;
		step_d     = step_q;
		byte_d     = PAD_BYTE;
		unique case (cur)
			STEP_LOAD_HI: begin byte_d = head_cmd.load_addr[15:8]; step_d = STEP_LOAD_LO; end
			STEP_LOAD_LO: begin byte_d = head_cmd.load_addr[7:0];  step_d = STEP_END_HI; end
			STEP_END_HI:  begin byte_d = head_cmd.end_addr[15:8];  step_d = STEP_END_LO; end
			STEP_END_LO:  begin byte_d = head_cmd.end_addr[7:0];   step_d = STEP_BODY; end
			STEP_BODY: begin
				byte_d = head_cmd.data_byte;
				step_d = head_cmd.last ? STEP_PAD0 : STEP_IDLE;
			end
			STEP_PAD0:    begin byte_d = PAD_BYTE;                step_d = STEP_PAD1; end
			STEP_PAD1:    begin byte_d = PAD_BYTE;                step_d = STEP_SYNC; end
			STEP_SYNC:    begin byte_d = SYNC_BYTE;               step_d = STEP_CS_HI; end
			STEP_CS_HI:   begin byte_d = head_cmd.checksum[15:8]; step_d = STEP_CS_LO; end
			STEP_CS_LO:   begin byte_d = head_cmd.checksum[7:0];  step_d = STEP_IDLE; end
			default:      begin byte_d = PAD_BYTE;                step_d = STEP_IDLE; end
		endcase
		if (!emit) begin
			step_d = step_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_IDLE;
			valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (advance) begin
				valid_q <= !q_stat.empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q       <= byte_d;
			run_end_q    <= final_step;
			record_end_q <= (cur == STEP_CS_LO);
		end
	end
endmodule
`default_nettype wire

@@ src/rk_tape_record_framer.sv @@
// Top level of the tape record framer: APB registers, front, queue and back.
// Depends on rktf_pkg, rktf_in_if, rktf_out_if, rktf_front, rktf_queue, rktf_back.
`timescale 1ns / 1ps
`default_nettype none
// Frames body bytes into a tape record: a 4-byte header (load address, end
// address, high byte first) ahead of the first byte, the bytes themselves, and
// after the byte marked is_last the footer 00 00 E6 and the 16-bit checksum.
// Each request on the input yields one to ten output bytes, one per cycle; the
// output port sets the pace, so a body byte inside a record yields one output byte, a
// record's first byte five and its last byte six. A queue of QUEUE_DEPTH
// commands lets the input run ahead while the back emits header and footer.
// Registers: load_address at 0x0, body_length at 0x4; write them only while
// the block is idle, a header takes the values present at its first byte.
module rk_tape_record_framer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire [2:0]   paddr,
	input  wire [31:0]  pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	rktf_in_if.sink     in_ch,
	rktf_out_if.source  out_ch
);
	import rktf_pkg::*;

	localparam logic REG_LOAD   = 1'b0;
	localparam logic REG_LENGTH = 1'b1;

	logic [15:0] load_q;
	logic [16:0] length_q;
	logic        wr_en;
	logic        push;
	logic        pop;
	cmd_t        push_cmd;
	cmd_t        head_cmd;
	q_stat_t     q_stat;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			REG_LOAD:   prdata = {16'h0000, load_q};
			REG_LENGTH: prdata = {15'h0000, length_q};
			default:    prdata = 32'h0000_0000;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q   <= 16'h0000;
			length_q <= 17'd1;
		end else if (wr_en) begin
			if (paddr[2] == REG_LOAD) begin
				load_q <= pwdata[15:0];
			end else begin
				length_q <= pwdata[16:0];
			end
		end
	end

	rktf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.load_address (load_q),
		.body_length  (length_q),
		.q_stat       (q_stat),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	rktf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.q_stat   (q_stat)
	);

	rktf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_cmd (head_cmd),
		.q_stat   (q_stat),
		.pop      (pop),
		.out_ch   (out_ch)
	);

	// The checksum low byte always closes the run of its request.
	a_rec_end_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.record_end |-> out_ch.run_end)
		else $error("record_end without run_end");

	// A record is at least ten bytes long, so two record ends never follow.
	a_rec_end_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && out_ch.record_end
		|=> !(out_ch.valid && out_ch.record_end))
		else $error("record ends on consecutive bytes");

	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty");

	// Nothing leaves the queue that was not handed over by the front.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");
endmodule
`default_nettype wire

@@ sim/rk_tape_record_framer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for rk_tape_record_framer: it frames random and corner-case
// body bytes through the block and compares every record byte with its own framing model.
// Depends on rktf_pkg, rktf_in_if, rktf_out_if and the framer RTL.
module rk_tape_record_framer_tb;
	import rktf_pkg::*;

	localparam logic [2:0] ADDR_LOAD = 3'h0;
	localparam logic [2:0] ADDR_LEN  = 3'h4;
	localparam int         LIMIT     = 300000;

	typedef struct packed {
		logic [7:0] out_val;
		logic       run_end;
		logic       record_end;
	} framed_byte_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rktf_in_if  in_bus ();
	rktf_out_if out_bus ();

	rk_tape_record_framer DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_bus),
		.out_ch  (out_bus)
	);

	// Framing model state and register copies.
	logic [15:0]  reg_load;
	logic [16:0]  reg_len;
	logic         rec_open;
	logic [15:0]  rec_sum;
	framed_byte_t framed_q[$];

	int src_idle_pct;
	int snk_idle_pct;
	int mismatches;
	int bytes_checked;
	int bytes_sent;
	int records_closed;
	int cycle_count;

	always #5 clk = ~clk;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_bus.valid = 1'b0;
		in_bus.data_byte = '0;
		in_bus.is_last = 1'b0;
		out_bus.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("Timeout after %0d cycles, %0d record bytes still due", cycle_count,
				framed_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	function automatic void push_framed(input logic [7:0] v, input logic re, input logic rec);
		framed_byte_t fb;
		fb.out_val = v;
		fb.run_end = re;
		fb.record_end = rec;
		framed_q.insert(framed_q.size(), fb);
	endfunction

	// Work out the record bytes that one accepted body byte produces.
	function automatic void frame_request(input logic [7:0] d, input logic is_last);
		logic [31:0] end_wide;
		logic [15:0] end_addr;
		logic [15:0] cs;
		if (!rec_open) begin
			end_wide = {16'b0, reg_load} + {15'b0, reg_len} + 32'h0000_FFFF;
			end_addr = end_wide[15:0];
			push_framed(reg_load[15:8], 1'b0, 1'b0);
			push_framed(reg_load[7:0], 1'b0, 1'b0);
			push_framed(end_addr[15:8], 1'b0, 1'b0);
			push_framed(end_addr[7:0], 1'b0, 1'b0);
			rec_open = 1'b1;
			rec_sum = '0;
		end
		if (!is_last) begin
			push_framed(d, 1'b1, 1'b0);
			rec_sum = rec_sum + {d, d};
		end else begin
			// The closing byte only touches the low checksum byte; no carry upward.
			cs = {rec_sum[15:8], rec_sum[7:0] + d};
			push_framed(d, 1'b0, 1'b0);
			push_framed(PAD_BYTE, 1'b0, 1'b0);
			push_framed(PAD_BYTE, 1'b0, 1'b0);
			push_framed(SYNC_BYTE, 1'b0, 1'b0);
			push_framed(cs[15:8], 1'b0, 1'b0);
			push_framed(cs[7:0], 1'b1, 1'b1);
			rec_open = 1'b0;
			rec_sum = '0;
			records_closed++;
		end
	endfunction

	always @(posedge clk) begin
		framed_byte_t want;
		if (out_bus.valid && out_bus.ready) begin
			bytes_checked++;
			if (framed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected record byte %02h run_end %b record_end %b", $time,
						out_bus.out_byte, out_bus.run_end, out_bus.record_end);
			end else begin
				want = framed_q.pop_front();
				if (out_bus.out_byte !== want.out_val || out_bus.run_end !== want.run_end
						|| out_bus.record_end !== want.record_end) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: record byte mismatch: expected %02h/%b/%b, got %02h/%b/%b",
							$time, want.out_val, want.run_end, want.record_end,
							out_bus.out_byte, out_bus.run_end, out_bus.record_end);
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic is_last);
		while ($urandom_range(99) < src_idle_pct) begin
			in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.data_byte <= d;
		in_bus.is_last <= is_last;
		frame_request(d, is_last);
		bytes_sent++;
		do @(posedge clk); while (!in_bus.ready);
	endtask

	// Lower valid and let every outstanding record byte come out.
	task automatic wait_drained();
		in_bus.valid <= 1'b0;
		while (framed_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr) begin
			if (addr == ADDR_LOAD)
				reg_load = val[15:0];
			else if (addr == ADDR_LEN)
				reg_len = val[16:0];
		end
	endtask

	task automatic bus_release();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(input logic [31:0] load, input logic [31:0] len);
		reg_access(1'b1, ADDR_LOAD, load);
		reg_access(1'b1, ADDR_LEN, len);
		bus_release();
	endtask

	task automatic read_check(input logic [2:0] addr, input logic [31:0] want);
		reg_access(1'b0, addr, '0);
		if (prdata !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: register read at %0h: expected %08h, got %08h", $time, addr,
					want, prdata);
		end
	endtask

	task automatic test_registers();
		read_check(ADDR_LOAD, 32'h0000_0000);
		read_check(ADDR_LEN, 32'h0000_0001);
		set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		read_check(ADDR_LOAD, 32'h0000_FFFF);
		read_check(ADDR_LEN, 32'h0001_FFFF);
		bus_release();
		set_config(32'h0000_0000, 32'h0000_0001);
	endtask

	task automatic test_single_byte_records();
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		wait_drained();
	endtask

	// Header goes out once; FF bytes push the checksum through its carries, and the
	// record is shorter than the register claims.
	task automatic test_header_once();
		set_config(32'h0000_FFFF, 32'h0001_0000);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hFF, 1'b1);
		wait_drained();
	endtask

	task automatic test_end_address_wrap();
		set_config(32'h0000_0000, 32'h0000_0000);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b1);
		wait_drained();
		set_config(32'h0000_8001, 32'h0001_FFFF);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b1);
		wait_drained();
		set_config(32'h0000_1234, 32'h0000_FFFF);
		send_byte(8'h0F, 1'b0);
		send_byte(8'hF0, 1'b1);
		wait_drained();
	endtask

	// A register change while a record is open only shows in the next header.
	task automatic test_config_inside_record();
		set_config(32'h0000_4000, 32'h0000_0003);
		send_byte(8'h12, 1'b0);
		wait_drained();
		set_config(32'h0000_ABCD, 32'h0000_0010);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b1);
		send_byte(8'h78, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_records(input int src_pct, input int snk_pct, input int n_items);
		int left;
		int len;
		int k;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		left = n_items;
		while (left > 0) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
			if (len > left)
				len = left;
			for (k = 1; k <= len; k++)
				send_byte(8'($urandom_range(255)), k == len);
			left -= len;
		end
		wait_drained();
	endtask

	initial begin
		reg_load = 16'h0000;
		reg_len = 17'h00001;
		rec_open = 1'b0;
		rec_sum = '0;
		src_idle_pct = 15;
		snk_idle_pct = 47;
		mismatches = 0;
		bytes_checked = 0;
		bytes_sent = 0;
		records_closed = 0;
		cycle_count = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_registers();
		test_single_byte_records();
		test_header_once();
		test_end_address_wrap();
		test_config_inside_record();

		set_config($urandom_range(65535), $urandom_range(131071));
		test_random_records(15, 47, 55);
		set_config(32'h0000_FFFF, 32'h0000_0001);
		test_random_records(47, 15, 55);
		set_config($urandom_range(65535), 32'h0000_0000);
		test_random_records(0, 0, 55);

		in_bus.valid <= 1'b0;
		while (framed_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Run covered %0d body bytes in %0d records, %0d record bytes checked,",
			bytes_sent, records_closed, bytes_checked);
		$display("under three idle mixes and register settings from zero to full width.");
		if (mismatches == 0 && framed_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
